// ----- hw/rtl/pse_pkg.sv -----
`timescale 1ns / 1ps
package pse_pkg;

  localparam int WORD_W              = 32;
  localparam int SYM_W               = 8;
  localparam int STATUS_W            = 2;
  localparam int STACK_DEPTH_DEFAULT = 64;

  // character codes
  localparam logic [SYM_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [SYM_W-1:0] CH_NINE  = 8'd57;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_DIVZERO   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_FINISH
  } state_t;

endpackage

// ----- hw/rtl/pse_in_if.sv -----
`timescale 1ns / 1ps
interface pse_in_if import pse_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             end_of_expr;

  modport source (output valid, output symbol, output end_of_expr, input ready);
  modport sink (input valid, input symbol, input end_of_expr, output ready);
endinterface

// ----- hw/rtl/pse_out_if.sv -----
`timescale 1ns / 1ps
interface pse_out_if import pse_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] value;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

// ----- hw/rtl/postfix_stack_evaluator.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Payload                      Handshake
// in_chan   in   symbol[7:0], end_of_expr     valid/ready, word taken when both high
// out_chan  out  value[31:0] signed, status   valid/ready, word taken when both high
//
// Digits and ignored characters are handled in S_IDLE. For + - * the stack memory read
// of the left operand is registered, then S_EXEC computes and writes back the result.
// Divide waits in S_DIV for the radix-2 divider (one quotient bit a cycle).
// An end-of-expression word loads the result register in S_FINISH, waiting there while
// the previous result is still unclaimed. Reset clears the stack count and error.
// The result register decouples the output: the next word is taken while a result waits.
module postfix_stack_evaluator import pse_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
  input logic      clk,
  input logic      rst_n,
  pse_in_if.sink   in_chan,
  pse_out_if.source out_chan
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // Stack layout: top_r mirrors the top entry, the memory holds every entry
  // (including the top) at its index, so an operator needs only entry count-2.
  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  status_t           err_r, err_nxt;
  logic [WORD_W-1:0] top_r, top_nxt;
  logic              end_r, end_nxt;
  op_t               op_r, op_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_value_r, out_value_nxt;
  status_t           out_status_r, out_status_nxt;

  logic              in_accept;
  logic              is_digit;
  logic              is_op;
  op_t               op_dec;
  logic [WORD_W-1:0] digit_val;
  logic [CW-1:0]     lo_idx;
  logic [AW-1:0]     lo_addr;
  logic              full;
  logic              two_ok;
  logic              slot_free;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  logic              div_start;
  logic              div_done;
  logic [WORD_W-1:0] div_quo;
  logic [WORD_W-1:0] alu_res;

  pse_ram #(
    .WIDTH(WORD_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (lo_addr),
    .rdata (ram_rdata)
  );

  pse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ram_rdata),
    .divisor  (top_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_accept     = in_chan.valid && in_chan.ready;

  assign is_digit  = (in_chan.symbol >= CH_ZERO) && (in_chan.symbol <= CH_NINE);
  assign digit_val = {{(WORD_W-SYM_W){1'b0}}, in_chan.symbol - CH_ZERO};
  assign lo_idx    = count_r - CW'(2);
  assign lo_addr   = lo_idx[AW-1:0];
  assign full      = (count_r >= CW'(STACK_DEPTH));
  assign two_ok    = (count_r >= CW'(2));
  assign slot_free = !out_valid_r || out_chan.ready;

  // decode the operator character
  always_comb begin
    is_op  = 1'b1;
    op_dec = OP_ADD;
    unique case (in_chan.symbol)
      CH_PLUS:  op_dec = OP_ADD;
      CH_MINUS: op_dec = OP_SUB;
      CH_STAR:  op_dec = OP_MUL;
      CH_SLASH: op_dec = OP_DIV;
      default:  is_op  = 1'b0;
    endcase
  end

  // left operand comes from memory, right operand from the top register
  always_comb begin
    case (op_r)
      OP_ADD:  alu_res = ram_rdata + top_r;
      OP_SUB:  alu_res = ram_rdata - top_r;
      default: alu_res = ram_rdata * top_r;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    err_nxt        = err_r;
    top_nxt        = top_r;
    end_nxt        = end_r;
    op_nxt         = op_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = lo_addr;
    ram_wdata      = alu_res;
    div_start      = 1'b0;

    // drop the result once taken
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          end_nxt = in_chan.end_of_expr;
          op_nxt  = op_dec;
          if (in_chan.end_of_expr) begin
            state_nxt = S_FINISH;
          end
          if (is_digit) begin
            if (full) begin
              if (err_r == ST_OK) begin
                err_nxt = ST_OVERFLOW;
              end
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_r[AW-1:0];
              ram_wdata = digit_val;
              top_nxt   = digit_val;
              count_nxt = count_r + 1'b1;
            end
          end else if (is_op) begin
            if (two_ok) begin
              // fetch the left operand
              state_nxt = S_EXEC;
            end else if (err_r == ST_OK) begin
              err_nxt = ST_UNDERFLOW;
            end
          end
        end
      end

      S_EXEC: begin
        if (op_r == OP_DIV) begin
          if (top_r == '0) begin
            if (err_r == ST_OK) begin
              err_nxt = ST_DIVZERO;
            end
            state_nxt = end_r ? S_FINISH : S_IDLE;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end else begin
          ram_we    = 1'b1;
          top_nxt   = alu_res;
          count_nxt = count_r - 1'b1;
          state_nxt = end_r ? S_FINISH : S_IDLE;
        end
      end

      S_DIV: begin
        if (div_done) begin
          ram_we    = 1'b1;
          ram_wdata = div_quo;
          top_nxt   = div_quo;
          count_nxt = count_r - 1'b1;
          state_nxt = end_r ? S_FINISH : S_IDLE;
        end
      end

      S_FINISH: begin
        // hold until the result register is free, then emit and clear
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (count_r == '0) begin
            out_value_nxt  = '0;
            out_status_nxt = (err_r == ST_OK) ? ST_UNDERFLOW : err_r;
          end else begin
            out_value_nxt  = top_r;
            out_status_nxt = err_r;
          end
          count_nxt = '0;
          err_nxt   = ST_OK;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    top_r        <= top_nxt;
    end_r        <= end_nxt;
    op_r         <= op_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.value  = out_value_r;
  assign out_chan.status = out_status_r;

endmodule

// ----- hw/rtl/pse_ram.sv -----
`timescale 1ns / 1ps
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/pse_div.sv -----
`timescale 1ns / 1ps
module pse_div import pse_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic              done,
  output logic [WORD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(WORD_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] dsr_r, dsr_nxt;
  logic              neg_r, neg_nxt;
  logic [WORD_W-1:0] q_r, q_nxt;

  logic [WORD_W:0]   rem_sh;
  logic [WORD_W+1:0] diff;
  logic              take;
  logic [WORD_W-1:0] quo_step;

  assign rem_sh   = {rem_r, quo_r[WORD_W-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, dsr_r};
  assign take     = ~diff[WORD_W+1];
  assign quo_step = {quo_r[WORD_W-2:0], take};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    neg_nxt  = neg_r;
    q_nxt    = q_r;
    if (start) begin
      // work on magnitudes, fix the sign at the end
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(WORD_W);
      rem_nxt  = '0;
      quo_nxt  = dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
      dsr_nxt  = divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;
      neg_nxt  = dividend[WORD_W-1] ^ divisor[WORD_W-1];
    end else if (busy_r) begin
      rem_nxt = take ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
      quo_nxt = quo_step;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        q_nxt    = neg_r ? (~quo_step + 1'b1) : quo_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    neg_r <= neg_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
